// File: sv/sbc_pkg.sv
package sbc_pkg;

    // Byte address width of the configuration port.
    localparam int PADDR_W = 3;

    // Register word indexes, taken from paddr[PADDR_W-1:2].
    localparam logic REG_SPHERE_RADIUS = 1'b0;

    // Direction in which a box runs away from its corner along one axis.
    typedef enum logic {
        DIR_UP,
        DIR_DOWN
    } box_dir_t;

    // Axis order is x, y, z.
    localparam box_dir_t AXIS_DIR [3] = '{DIR_UP, DIR_DOWN, DIR_DOWN};

endpackage

// File: sv/sbc_apb_regs.sv
module sbc_apb_regs
    import sbc_pkg::*;
#(
    parameter int RADIUS_W = 23
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic [RADIUS_W-1:0] radius
);

    logic                radius_sel;
    logic [RADIUS_W-1:0] sphere_radius_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign radius_sel = (paddr[PADDR_W-1:2] == REG_SPHERE_RADIUS);
    assign wr_en = psel && penable && pwrite && pready && radius_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sphere_radius_reg <= RADIUS_W'(256);
        end else if (wr_en) begin
            sphere_radius_reg <= pwdata[RADIUS_W-1:0];
        end
    end

    // Addresses past the register list read as zero.
    assign prdata = radius_sel ? 32'(sphere_radius_reg) : 32'd0;
    assign radius = sphere_radius_reg;

endmodule

// File: sv/sbc_clamp.sv
module sbc_clamp
    import sbc_pkg::*;
#(
    parameter int CB = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CB-1:0] ball   [3],
    input  logic signed [CB-1:0] corner [3],
    input  logic        [CB-2:0] extent [3],
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CB:0]   delta  [3]
);

    logic v1_reg;
    logic v2_reg;
    logic rdy1;
    logic rdy2;

    logic signed [CB:0] ball1_reg  [3];
    logic signed [CB:0] lo1_reg    [3];
    logic signed [CB:0] hi1_reg    [3];
    logic signed [CB:0] ball1_next [3];
    logic signed [CB:0] lo1_next   [3];
    logic signed [CB:0] hi1_next   [3];
    logic signed [CB:0] delta2_reg  [3];
    logic signed [CB:0] delta2_next [3];

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [CB:0] corner_e;
        logic signed [CB:0] ext_e;

        assign corner_e = {corner[a][CB-1], corner[a]};
        assign ext_e    = {2'b00, extent[a]};
        assign ball1_next[a] = {ball[a][CB-1], ball[a]};

        // Box faces along this axis.
        if (AXIS_DIR[a] == DIR_UP) begin : g_up
            assign lo1_next[a] = corner_e;
            assign hi1_next[a] = corner_e + ext_e;
        end else begin : g_down
            assign lo1_next[a] = corner_e - ext_e;
            assign hi1_next[a] = corner_e;
        end

        // Centre minus its clamp into [lo, hi]; the difference always fits CB+1 bits.
        always_comb begin
            if (ball1_reg[a] < lo1_reg[a]) begin
                delta2_next[a] = ball1_reg[a] - lo1_reg[a];
            end else if (ball1_reg[a] > hi1_reg[a]) begin
                delta2_next[a] = ball1_reg[a] - hi1_reg[a];
            end else begin
                delta2_next[a] = '0;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy1 && in_valid) begin
                ball1_reg[a] <= ball1_next[a];
                lo1_reg[a]   <= lo1_next[a];
                hi1_reg[a]   <= hi1_next[a];
            end
            if (rdy2 && v1_reg) begin
                delta2_reg[a] <= delta2_next[a];
            end
        end

        assign delta[a] = delta2_reg[a];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    assign out_valid = v2_reg;

endmodule

// File: sv/sbc_dist.sv
module sbc_dist #(
    parameter int CB = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CB:0]   delta  [3],
    input  logic        [CB-2:0] radius,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic signed [CB:0]   offset [3]
);

    localparam int SQ_W  = 2 * CB - 2;
    localparam int SUM_W = 2 * CB;

    logic v3_reg;
    logic v4_reg;
    logic v5_reg;
    logic v6_reg;
    logic rdy3;
    logic rdy4;
    logic rdy5;
    logic rdy6;

    logic signed [CB:0]   d3_reg  [3];
    logic signed [CB:0]   d4_reg  [3];
    logic signed [CB:0]   d5_reg  [3];
    logic        [CB-2:0] mag3_reg  [3];
    logic        [CB-2:0] mag3_next [3];
    logic        [2:0]    near3_next;
    logic                 near3_reg;
    logic                 near4_reg;
    logic                 near5_reg;
    logic        [SQ_W-1:0]  sq4_reg [3];
    logic        [SQ_W-1:0]  rsq4_reg;
    logic        [SQ_W-1:0]  rsq5_reg;
    logic        [SUM_W-1:0] sum5_reg;
    logic        [SUM_W-1:0] sum5_next;
    logic                 hit6_reg;
    logic                 hit6_next;
    logic signed [CB:0]   off6_reg [3];

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [CB:0] mag;

        assign mag = delta[a][CB] ? (CB + 1)'(-delta[a]) : delta[a];
        // An axis at or beyond the radius rules out a hit, so its square may be truncated.
        assign near3_next[a] = (mag < {2'b00, radius});
        assign mag3_next[a]  = mag[CB-2:0];

        always_ff @(posedge aclk) begin
            if (rdy3 && in_valid) begin
                d3_reg[a]   <= delta[a];
                mag3_reg[a] <= mag3_next[a];
            end
            if (rdy4 && v3_reg) begin
                d4_reg[a]  <= d3_reg[a];
                sq4_reg[a] <= SQ_W'(mag3_reg[a]) * SQ_W'(mag3_reg[a]);
            end
            if (rdy5 && v4_reg) begin
                d5_reg[a] <= d4_reg[a];
            end
            if (rdy6 && v5_reg) begin
                off6_reg[a] <= hit6_next ? d5_reg[a] : '0;
            end
        end

        assign offset[a] = off6_reg[a];
    end

    assign sum5_next = SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);
    assign hit6_next = near5_reg && (sum5_reg < {2'b00, rsq5_reg});

    always_ff @(posedge aclk) begin
        if (rdy3 && in_valid) begin
            near3_reg <= &near3_next;
        end
        if (rdy4 && v3_reg) begin
            near4_reg <= near3_reg;
            rsq4_reg  <= SQ_W'(radius) * SQ_W'(radius);
        end
        if (rdy5 && v4_reg) begin
            near5_reg <= near4_reg;
            rsq5_reg  <= rsq4_reg;
            sum5_reg  <= sum5_next;
        end
        if (rdy6 && v5_reg) begin
            hit6_reg <= hit6_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy3) begin
                v3_reg <= in_valid;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
        end
    end

    assign out_valid = v6_reg;
    assign hit       = hit6_reg;

endmodule

// File: sv/sphere_box_collision_test_core.sv
// Channel   Direction  Ports                      Contents
// s_        in         s_tvalid s_tready s_tdata  one query item: sphere centre and box
// m_        out        m_tvalid m_tready m_tdata  one result item: hit flag and offset
// APB       in         psel penable pwrite ...    sphere_radius register at address 0
//
// The block takes one item every clock cycle while m_tready does not stall it, through six
// register stages: two form the box faces and clamp the centre, then one each for
// magnitudes, the squaring multipliers, the sum and the final compare.
// Reset (aresetn low, synchronous) empties the pipeline and sets the radius to 256.
// Each stage holds its item while the next stage is full and stalled, so a stall on m_tready
// backs up stage by stage and nothing is dropped or repeated.
module sphere_box_collision_test_core
    import sbc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    // Fields from bit 0 up: ball_x, ball_y, ball_z, box_x, box_y, box_z (COORD_BITS
    // each), box_length, box_height, box_width (COORD_BITS-1 each), zero fill.
    input  logic [((9*COORD_BITS-3+7)/8)*8-1:0] s_tdata,

    output logic                     m_tvalid,
    input  logic                     m_tready,
    // Fields from bit 0 up: hit (1), offset_x, offset_y, offset_z (COORD_BITS+1 each),
    // zero fill.
    output logic [((3*COORD_BITS+4+7)/8)*8-1:0] m_tdata,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int CB       = COORD_BITS;
    localparam int M_DATA_W = ((3 * CB + 4 + 7) / 8) * 8;

    logic        [CB-2:0] radius;
    logic signed [CB-1:0] ball   [3];
    logic signed [CB-1:0] corner [3];
    logic        [CB-2:0] extent [3];
    logic signed [CB:0]   delta  [3];
    logic signed [CB:0]   offset [3];
    logic                 mid_valid;
    logic                 mid_ready;
    logic                 hit;

    // Unpack the query item. Coordinates come first, extents after them.
    for (genvar a = 0; a < 3; a++) begin : g_unpack
        assign ball[a]   = s_tdata[a*CB +: CB];
        assign corner[a] = s_tdata[(3 + a)*CB +: CB];
        assign extent[a] = s_tdata[6*CB + a*(CB-1) +: CB-1];
    end

    sbc_apb_regs #(
        .RADIUS_W (CB - 1)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .radius  (radius)
    );

    // Box faces and the per-axis distance from the centre to the box.
    sbc_clamp #(
        .CB (CB)
    ) u_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .ball      (ball),
        .corner    (corner),
        .extent    (extent),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .delta     (delta)
    );

    // Squared distance against the squared radius; the offset is zeroed on a miss.
    sbc_dist #(
        .CB (CB)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .delta     (delta),
        .radius    (radius),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hit       (hit),
        .offset    (offset)
    );

    assign m_tdata = M_DATA_W'({offset[2], offset[1], offset[0], hit});

`ifndef ASSERT_OFF
    // A miss always carries a zero offset.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !hit |-> offset[0] == '0 && offset[1] == '0 && offset[2] == '0)
        else $error("miss result with nonzero offset");

    // With a zero radius no distance can be below it.
    a_zero_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && radius == '0 |-> !hit)
        else $error("hit reported with zero radius");

    // The input side only stalls when every stage is full and the output is blocked.
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the pipeline has room");
`endif

endmodule
